FILE: rtl/aclru_pkg.sv
// Shared constants and types for the associative LFU/LRU cache.
package aclru_pkg;

  localparam int CAPACITY = 16;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 31;
  localparam int VAL_W    = 16;
  localparam int USE_W    = 16;
  localparam int STAMP_W  = 32;
  localparam int TOTAL_W  = 32;
  localparam int CFG_W    = 5;

  // Item actions
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  // Replacement policies
  localparam logic POL_LFU = 1'b0;
  localparam logic POL_LRU = 1'b1;

  // Configuration register indexes
  localparam logic REG_ENTRIES = 1'b0;
  localparam logic REG_POLICY  = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [USE_W-1:0]   count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

FILE: rtl/assoc_cache_lfu_lru.sv
// Fully associative key/value cache with LFU or LRU replacement.
//
// Each item is scanned over the n active slots of the entry memory, which has one
// read port and returns one entry per cycle; the read data is registered, and after
// the last entry is compared the updated entry is written back. The write-back
// waits while a previous result is stalled in the output register. A new item is
// accepted in the cycle after the previous result enters the output register, even
// while that result is still stalled. Valid bits live in flip-flops and are
// cleared at reset, so no clearing pass is needed.
module assoc_cache_lfu_lru import aclru_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [VAL_W-1:0]   value_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic [VAL_W-1:0]   value_out_o,
  output logic [SLOT_W-1:0]  slot_o,
  output logic               replaced_o,
  output logic [TOTAL_W-1:0] hit_total_o,
  output logic [TOTAL_W-1:0] miss_total_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  localparam logic [CNT_W-1:0] CAP_N = CNT_W'(CAPACITY);

  // Entry memory
  entry_t mem [CAPACITY];
  entry_t rd_data_q;
  logic [SLOT_W-1:0] rd_addr;
  logic              mem_we;
  logic [SLOT_W-1:0] wr_addr;
  entry_t            wr_data;

  logic [CAPACITY-1:0] valid_q, valid_d;

  logic [1:0] state_q, state_d;
  logic [CFG_W-1:0] entries_q;
  logic             policy_q;

  logic               action_q;
  logic [KEY_W-1:0]   key_q;
  logic [VAL_W-1:0]   val_q;
  logic [STAMP_W-1:0] tick_q;
  logic [TOTAL_W-1:0] hits_q, hits_d;
  logic [TOTAL_W-1:0] misses_q, misses_d;

  logic [CNT_W-1:0]  issue_idx_q;
  logic              rd_pend_q;
  logic [SLOT_W-1:0] rd_idx_q;

  logic               found_q;
  logic [SLOT_W-1:0]  match_idx_q;
  entry_t             match_q;
  logic [SLOT_W-1:0]  best_idx_q;
  logic [STAMP_W-1:0] best_metric_q;

  logic               out_vld_q;
  logic               hit_q;
  logic [VAL_W-1:0]   vout_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               repl_q;

  logic [CNT_W-1:0]   n_active;
  logic               issue_more;
  logic               accept;
  logic               wb_go;
  logic               empty_found;
  logic [SLOT_W-1:0]  empty_idx;
  logic [STAMP_W-1:0] metric;
  logic [SLOT_W-1:0]  ins_idx;

  // Clamp the active slot count to 1..CAPACITY
  always_comb begin
    if (entries_q == '0) begin
      n_active = CNT_W'(1);
    end else if (CNT_W'(entries_q) > CAP_N) begin
      n_active = CAP_N;
    end else begin
      n_active = CNT_W'(entries_q);
    end
  end

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign issue_more = (issue_idx_q < n_active);
  assign rd_addr    = issue_idx_q[SLOT_W-1:0];
  assign wb_go      = (state_q == ST_WB) && (!out_vld_q || !out_stall_i);

  // First empty active slot
  always_comb begin
    empty_found = 1'b0;
    empty_idx   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_q[i] && (CNT_W'(i) < n_active)) begin
        empty_found = 1'b1;
        empty_idx   = SLOT_W'(i);
      end
    end
  end

  assign metric  = (policy_q == POL_LFU) ? STAMP_W'(rd_data_q.count) : rd_data_q.stamp;
  assign ins_idx = empty_found ? empty_idx : best_idx_q;

  // Write-back data, valid bits and hit/miss totals
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = match_idx_q;
    wr_data = match_q;
    valid_d = valid_q;
    hits_d  = hits_q;
    misses_d = misses_q;
    if (action_q == ACT_LOOKUP) begin
      if (found_q) begin
        mem_we = wb_go;
        if (policy_q == POL_LFU) begin
          if (match_q.count != '1) begin
            wr_data.count = match_q.count + USE_W'(1);
          end
        end else begin
          wr_data.stamp = tick_q;
        end
        if (hits_q != '1) begin
          hits_d = hits_q + TOTAL_W'(1);
        end
      end else if (misses_q != '1) begin
        misses_d = misses_q + TOTAL_W'(1);
      end
    end else begin
      mem_we        = wb_go;
      wr_addr       = ins_idx;
      wr_data.key   = key_q;
      wr_data.value = val_q;
      wr_data.count = USE_W'(1);
      wr_data.stamp = tick_q;
      valid_d[ins_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue_more && rd_pend_q) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        if (wb_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      entries_q   <= CFG_W'(CAPACITY);
      policy_q    <= POL_LFU;
      valid_q     <= '0;
      tick_q      <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      issue_idx_q <= '0;
      rd_pend_q   <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_ENTRIES) begin
          entries_q <= cfg_data_i;
        end else begin
          policy_q <= cfg_data_i[0];
        end
      end
      if (accept) begin
        issue_idx_q <= '0;
        rd_pend_q   <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        rd_pend_q <= issue_more;
        if (issue_more) begin
          issue_idx_q <= issue_idx_q + CNT_W'(1);
        end
      end
      if (wb_go) begin
        valid_q   <= valid_d;
        hits_q    <= hits_d;
        misses_q  <= misses_d;
        tick_q    <= tick_q + STAMP_W'(1);
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Item payload, scan results and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      key_q    <= key_i;
      val_q    <= value_in_i;
      found_q  <= 1'b0;
    end
    if (state_q == ST_SCAN) begin
      rd_idx_q <= rd_addr;
    end
    if (state_q == ST_SCAN && rd_pend_q) begin
      if (!found_q && valid_q[rd_idx_q] && (rd_data_q.key == key_q)) begin
        found_q     <= 1'b1;
        match_idx_q <= rd_idx_q;
        match_q     <= rd_data_q;
      end
      // Lowest index wins on a tie
      if (rd_idx_q == '0 || metric < best_metric_q) begin
        best_idx_q    <= rd_idx_q;
        best_metric_q <= metric;
      end
    end
    if (wb_go) begin
      hit_q  <= (action_q == ACT_LOOKUP) && found_q;
      vout_q <= ((action_q == ACT_LOOKUP) && found_q) ? match_q.value : '0;
      repl_q <= (action_q == ACT_INSERT) && !empty_found;
      if (action_q == ACT_INSERT) begin
        slot_q <= ins_idx;
      end else if (found_q) begin
        slot_q <= match_idx_q;
      end else begin
        slot_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign hit_o        = hit_q;
  assign value_out_o  = vout_q;
  assign slot_o       = slot_q;
  assign replaced_o   = repl_q;
  assign hit_total_o  = hits_q;
  assign miss_total_o = misses_q;

  // The entry memory is only written while no scan is running
  a_we_in_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_WB))
    else $error("entry memory written outside write-back");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (issue_idx_q <= n_active))
    else $error("scan ran past the active slots");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN))
    else $error("accepted item did not start a scan");

  a_hit_not_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(hit_q && repl_q))
    else $error("result both hit and replaced");

  a_insert_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wb_go && action_q == ACT_INSERT) |=> valid_q[$past(ins_idx)])
    else $error("inserted slot not marked valid");

endmodule
